/* src/image_plane_orientation_macros.svh */
// Assertion macros shared by the image plane orientation RTL.
`ifndef IMAGE_PLANE_ORIENTATION_MACROS_SVH
`define IMAGE_PLANE_ORIENTATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPO_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("image plane orientation check failed");

// Consequent must hold in the cycle after the antecedent.
`define IPO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("image plane orientation check failed");

`endif

/* src/iporient_pkg.sv */
// Shared constants, types and codes of the image plane orientation block.
package iporient_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int MAX_HEIGHT  = 64;
	localparam int MAX_SIDE    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LC_W        = $clog2(STORE_DEPTH + 1);
	localparam int POS_W       = $clog2(MAX_SIDE);
	localparam int DIM_W       = 7;
	localparam int MODE_W      = 3;
	localparam int PIX_W       = 8;
	localparam int REG_IDX_W   = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE   = 3'd0,
		MODE_ROT90  = 3'd1,
		MODE_ROT180 = 3'd2,
		MODE_ROT270 = 3'd3,
		MODE_MIRH   = 3'd4,
		MODE_MIRV   = 3'd5
	} mode_t;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd2;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  wdata;
		logic              result;
		logic              last;
		logic              not_ready;
	} req_t;

endpackage

/* src/iporient_store.sv */
// Frame store: single-port synchronous memory with registered read data.
module iporient_store (
	input  logic                                       clk,
	input  iporient_pkg::req_t                         req,
	output logic [iporient_pkg::PIX_W-1:0]             rdata
);

	logic [iporient_pkg::PIX_W-1:0] mem [iporient_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

/* src/iporient_ctrl.sv */
// Configuration registers, load counter, output scan position and address generation.
module iporient_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [iporient_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [iporient_pkg::DIM_W-1:0]         cfg_data,
	input  logic                                   acc,
	input  logic                                   cmd,
	input  logic [iporient_pkg::PIX_W-1:0]         pixel_in,
	output iporient_pkg::req_t                     req
);

	localparam int DW = iporient_pkg::DIM_W;

	logic [DW-1:0]                       plane_width_q;
	logic [DW-1:0]                       plane_height_q;
	logic [iporient_pkg::MODE_W-1:0]     transform_mode_q;
	logic [iporient_pkg::LC_W-1:0]       load_count_q;
	logic [iporient_pkg::POS_W-1:0]      out_col_q;
	logic [iporient_pkg::POS_W-1:0]      out_row_q;
	logic                                plane_loaded_q;

	logic [DW-1:0]                       w_eff, h_eff, ow, oh, x, y, sx, sy;
	logic [2*DW-1:0]                     total_full, addr_full;
	logic [iporient_pkg::LC_W-1:0]       total, lc_next;
	logic                                room, is_last, row_end;
	iporient_pkg::mode_t                 mode;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (plane_width_q == '0) begin
			w_eff = DW'(1);
		end else if (plane_width_q > DW'(iporient_pkg::MAX_WIDTH)) begin
			w_eff = DW'(iporient_pkg::MAX_WIDTH);
		end else begin
			w_eff = plane_width_q;
		end
		if (plane_height_q == '0) begin
			h_eff = DW'(1);
		end else if (plane_height_q > DW'(iporient_pkg::MAX_HEIGHT)) begin
			h_eff = DW'(iporient_pkg::MAX_HEIGHT);
		end else begin
			h_eff = plane_height_q;
		end
		if (transform_mode_q > iporient_pkg::MODE_W'(iporient_pkg::MODE_MIRV)) begin
			mode = iporient_pkg::MODE_NONE;
		end else begin
			mode = iporient_pkg::mode_t'(transform_mode_q);
		end
	end

	assign total_full = (2*DW)'(w_eff) * (2*DW)'(h_eff);
	assign total      = total_full[iporient_pkg::LC_W-1:0];
	assign room       = load_count_q < total;
	assign lc_next    = room ? load_count_q + 1'b1 : load_count_q;

	always_comb begin
		if (mode == iporient_pkg::MODE_ROT90 || mode == iporient_pkg::MODE_ROT270) begin
			ow = h_eff;
			oh = w_eff;
		end else begin
			ow = w_eff;
			oh = h_eff;
		end
		x = (DW'(out_col_q) < ow) ? DW'(out_col_q) : ow - 1'b1;
		y = (DW'(out_row_q) < oh) ? DW'(out_row_q) : oh - 1'b1;
		unique case (mode)
			iporient_pkg::MODE_ROT90: begin
				sx = w_eff - 1'b1 - y;
				sy = x;
			end
			iporient_pkg::MODE_ROT180: begin
				sx = w_eff - 1'b1 - x;
				sy = h_eff - 1'b1 - y;
			end
			iporient_pkg::MODE_ROT270: begin
				sx = y;
				sy = h_eff - 1'b1 - x;
			end
			iporient_pkg::MODE_MIRH: begin
				sx = w_eff - 1'b1 - x;
				sy = y;
			end
			iporient_pkg::MODE_MIRV: begin
				sx = x;
				sy = h_eff - 1'b1 - y;
			end
			default: begin
				sx = x;
				sy = y;
			end
		endcase
	end

	assign addr_full = (2*DW)'(sy) * (2*DW)'(w_eff) + (2*DW)'(sx);
	assign row_end   = (x == ow - 1'b1);
	assign is_last   = row_end && (y == oh - 1'b1);

	always_comb begin
		req           = '0;
		req.wdata     = pixel_in;
		if (cmd == iporient_pkg::CMD_WRITE) begin
			req.addr  = load_count_q[iporient_pkg::ADDR_W-1:0];
			req.wr_en = acc && !plane_loaded_q && room;
		end else begin
			req.addr      = addr_full[iporient_pkg::ADDR_W-1:0];
			req.result    = 1'b1;
			req.not_ready = !plane_loaded_q;
			req.rd_en     = acc && plane_loaded_q;
			req.last      = plane_loaded_q && is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_width_q    <= DW'(64);
			plane_height_q   <= DW'(64);
			transform_mode_q <= iporient_pkg::MODE_W'(iporient_pkg::MODE_NONE);
			load_count_q     <= '0;
			out_col_q        <= '0;
			out_row_q        <= '0;
			plane_loaded_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					iporient_pkg::REG_WIDTH:  plane_width_q    <= cfg_data;
					iporient_pkg::REG_HEIGHT: plane_height_q   <= cfg_data;
					iporient_pkg::REG_MODE:   transform_mode_q <= cfg_data[iporient_pkg::MODE_W-1:0];
					default: ;
				endcase
			end
			if (acc && !plane_loaded_q && cmd == iporient_pkg::CMD_WRITE) begin
				load_count_q   <= lc_next;
				plane_loaded_q <= (lc_next >= total);
			end
			if (acc && plane_loaded_q && cmd == iporient_pkg::CMD_READ) begin
				if (is_last) begin
					out_col_q      <= '0;
					out_row_q      <= '0;
					load_count_q   <= '0;
					plane_loaded_q <= 1'b0;
				end else if (row_end) begin
					out_col_q <= '0;
					out_row_q <= iporient_pkg::POS_W'(y + 1'b1);
				end else begin
					out_col_q <= iporient_pkg::POS_W'(x + 1'b1);
					out_row_q <= iporient_pkg::POS_W'(y);
				end
			end
		end
	end

endmodule

/* src/image_plane_orientation.sv */
// Top level of the image plane orientation block.
// The block stores one 8-bit plane of up to 64 x 64 pixels, written in raster order by
// transactions with tuser = 0, and returns it on transactions with tuser = 1 in output
// raster order, rotated counter-clockwise by 90, 180 or 270 degrees or mirrored as
// transform_mode selects. Both kinds of transaction are taken at one per clock cycle
// while the master side does not stall; the frame store is a single-port memory, so each
// transaction uses its one port once. A read result passes the store read register and
// the output register. A read issued before the whole plane is loaded returns tuser = 1
// with zero data and changes nothing; the tlast read re-arms it for the next plane.
// Configuration is taken at any time but should only change while the block is idle.
`include "image_plane_orientation_macros.svh"

module image_plane_orientation (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [iporient_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [iporient_pkg::DIM_W-1:0]         cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [iporient_pkg::PIX_W-1:0]         s_tdata,   // [7:0] pixel_in
	input  logic                                   s_tuser,   // [0] cmd
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [iporient_pkg::PIX_W-1:0]         m_tdata,   // [7:0] pixel_out
	output logic                                   m_tlast,
	output logic                                   m_tuser    // [0] not_ready
);

	iporient_pkg::req_t             req;
	logic [iporient_pkg::PIX_W-1:0] rdata;
	logic                           acc, adv;
	logic                           valid_s1, last_s1, nr_s1;
	logic                           out_valid_q, out_last_q, out_nr_q;
	logic [iporient_pkg::PIX_W-1:0] out_pix_q;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign acc      = s_tvalid && s_tready;

	iporient_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.cmd       (s_tuser),
		.pixel_in  (s_tdata),
		.req       (req)
	);

	iporient_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= req.result;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			last_s1 <= req.last;
			nr_s1   <= req.not_ready;
		end
		if (adv) begin
			out_pix_q  <= nr_s1 ? '0 : rdata;
			out_last_q <= last_s1;
			out_nr_q   <= nr_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_nr_q;

	`IPO_ASSERT_NEXT(a_write_no_result, acc && s_tuser == iporient_pkg::CMD_WRITE, !valid_s1)
	`IPO_ASSERT_NEXT(a_read_in_s1, acc && s_tuser == iporient_pkg::CMD_READ, valid_s1)
	`IPO_ASSERT_NOW(a_not_ready_clean, m_tvalid && m_tuser, m_tdata == '0 && !m_tlast)

endmodule

/* verif/tb_image_plane_orientation.sv */
// Self-checking testbench of the image plane orientation block with a built-in predictor.
`timescale 1ns / 1ps

module tb_image_plane_orientation;
	import iporient_pkg::*;

	localparam int SETTLE_CYCLES   = 8;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int WATCHDOG_NS     = 2_000_000;
	localparam int REPORT_LIMIT    = 10;

	localparam logic [REG_IDX_W-1:0] REG_SPARE   = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_UNUSED = 3'd7;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
		logic             not_ready;
	} orient_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [DIM_W-1:0]     reg_val;
		logic                 cmd;
		logic [PIX_W-1:0]     pixel;
		bit                   typed;
		orient_result_t       golden;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [PIX_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;

	logic [PIX_W-1:0]  img_store [STORE_DEPTH];
	int                fill_count;
	int                col_pos;
	int                row_pos;
	bit                plane_full;
	logic [DIM_W-1:0]  width_reg;
	logic [DIM_W-1:0]  height_reg;
	logic [MODE_W-1:0] mode_reg;

	orient_result_t expected_pixels [$];
	stim_row_t      directed_rows [$];

	int       error_count;
	int       items_sent;
	int       results_checked;
	int       not_ready_seen;
	int       planes_done;
	bit [7:0] modes_hit;
	int       tx_idle_pct;
	int       rx_idle_pct;
	int       rx_hold_left;

	image_plane_orientation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("Timeout with %0d results still outstanding", expected_pixels.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int eff_side(input logic [DIM_W-1:0] v, input int limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	task automatic predict_orientation(input logic cmd, input logic [PIX_W-1:0] pix,
			output bit has_res, output orient_result_t res);
		int w, h, ow, oh, x, y, sx, sy;
		bit at_end;
		w = eff_side(width_reg, MAX_WIDTH);
		h = eff_side(height_reg, MAX_HEIGHT);
		has_res = 1'b0;
		res = '0;
		if (cmd == CMD_WRITE) begin
			if (!plane_full) begin
				if (fill_count < w * h) begin
					img_store[fill_count] = pix;
					fill_count++;
				end
				plane_full = (fill_count >= w * h);
			end
		end else if (!plane_full) begin
			has_res = 1'b1;
			res.not_ready = 1'b1;
		end else begin
			if (mode_reg == MODE_ROT90 || mode_reg == MODE_ROT270) begin
				ow = h;
				oh = w;
			end else begin
				ow = w;
				oh = h;
			end
			x = (col_pos < ow) ? col_pos : ow - 1;
			y = (row_pos < oh) ? row_pos : oh - 1;
			case (mode_reg)
				MODE_ROT90: begin
					sx = w - 1 - y;
					sy = x;
				end
				MODE_ROT180: begin
					sx = w - 1 - x;
					sy = h - 1 - y;
				end
				MODE_ROT270: begin
					sx = y;
					sy = h - 1 - x;
				end
				MODE_MIRH: begin
					sx = w - 1 - x;
					sy = y;
				end
				MODE_MIRV: begin
					sx = x;
					sy = h - 1 - y;
				end
				default: begin
					sx = x;
					sy = y;
				end
			endcase
			at_end = (x == ow - 1) && (y == oh - 1);
			has_res = 1'b1;
			res.pixel = img_store[sy * w + sx];
			res.last = at_end;
			modes_hit[mode_reg] = 1'b1;
			if (at_end) begin
				col_pos = 0;
				row_pos = 0;
				fill_count = 0;
				plane_full = 1'b0;
			end else if (x + 1 >= ow) begin
				col_pos = 0;
				row_pos = y + 1;
			end else begin
				col_pos = x + 1;
				row_pos = y;
			end
		end
	endtask

	function automatic void add_cfg_row(input logic [REG_IDX_W-1:0] idx,
			input logic [DIM_W-1:0] val);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		r.cmd = CMD_WRITE;
		r.pixel = '0;
		r.typed = 1'b0;
		r.golden = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_item_row(input logic cmd, input logic [PIX_W-1:0] pix);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.reg_idx = REG_WIDTH;
		r.reg_val = '0;
		r.cmd = cmd;
		r.pixel = pix;
		r.typed = 1'b0;
		r.golden = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_golden_row(input logic cmd, input logic [PIX_W-1:0] pix,
			input logic [PIX_W-1:0] exp_pix, input logic exp_last, input logic exp_nr);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.reg_idx = REG_WIDTH;
		r.reg_val = '0;
		r.cmd = cmd;
		r.pixel = pix;
		r.typed = 1'b1;
		r.golden = {exp_pix, exp_last, exp_nr};
		directed_rows.push_back(r);
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("[%0t] %s", $realtime, msg);
	endtask

	task automatic send_pixel_txn(input logic cmd, input logic [PIX_W-1:0] pix,
			input bit use_typed, input orient_result_t typed);
		bit has_res;
		orient_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= pix;
		do
			@(posedge clk);
		while (!s_tready);
		if (cmd == CMD_READ || !plane_full)
			items_sent++;
		predict_orientation(cmd, pix, has_res, res);
		if (has_res)
			expected_pixels.push_back(use_typed ? typed : res);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_WIDTH:  width_reg = val;
			REG_HEIGHT: height_reg = val;
			REG_MODE:   mode_reg = val[MODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic await_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_plane(input bit squeeze);
		logic [DIM_W-1:0] wv, hv;
		orient_result_t none;
		int pick, k, cut, reshape, cw, ch;
		none = '0;
		pick = $urandom_range(99);
		if (squeeze) begin
			wv = DIM_W'(8);
			hv = DIM_W'(8);
		end else if (pick < 6) begin
			wv = '0;
			hv = DIM_W'($urandom_range(1, 6));
		end else if (pick < 12) begin
			wv = DIM_W'($urandom_range(64, 127));
			hv = DIM_W'($urandom_range(0, 3));
		end else if (pick < 18) begin
			wv = DIM_W'($urandom_range(0, 3));
			hv = DIM_W'($urandom_range(64, 127));
		end else begin
			wv = DIM_W'($urandom_range(1, 8));
			hv = DIM_W'($urandom_range(1, 8));
		end
		await_results();
		write_reg(REG_WIDTH, wv);
		write_reg(REG_HEIGHT, hv);
		write_reg(REG_MODE, DIM_W'($urandom_range(7)));

		cut = ($urandom_range(7) == 0) ? $urandom_range(1, 12) : -1;
		k = 0;
		while (!plane_full) begin
			if ($urandom_range(11) == 0)
				send_pixel_txn(CMD_READ, PIX_W'($urandom_range(255)), 1'b0, none);
			if (k == cut) begin
				await_results();
				write_reg(REG_WIDTH, DIM_W'($urandom_range(1, 4)));
				write_reg(REG_HEIGHT, DIM_W'($urandom_range(1, 4)));
			end
			send_pixel_txn(CMD_WRITE, PIX_W'($urandom_range(255)), 1'b0, none);
			k++;
		end
		if ($urandom_range(3) == 0)
			send_pixel_txn(CMD_WRITE, PIX_W'($urandom_range(255)), 1'b0, none);

		if (squeeze)
			rx_hold_left = 300;
		reshape = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : -1;
		k = 0;
		while (plane_full) begin
			if (k == reshape) begin
				await_results();
				cw = eff_side(width_reg, MAX_WIDTH);
				ch = eff_side(height_reg, MAX_HEIGHT);
				if ($urandom_range(1) == 0) begin
					write_reg(REG_WIDTH, DIM_W'(ch));
					write_reg(REG_HEIGHT, DIM_W'(cw));
				end else begin
					write_reg(REG_WIDTH, DIM_W'($urandom_range(1, cw)));
					write_reg(REG_HEIGHT, DIM_W'($urandom_range(1, ch)));
				end
				write_reg(REG_MODE, DIM_W'($urandom_range(7)));
			end
			if ($urandom_range(19) == 0)
				send_pixel_txn(CMD_WRITE, PIX_W'($urandom_range(255)), 1'b0, none);
			send_pixel_txn(CMD_READ, PIX_W'($urandom_range(255)), 1'b0, none);
			k++;
		end
		planes_done++;
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		orient_result_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tlast, m_tuser};
			if (expected_pixels.size() == 0) begin
				flag_error($sformatf("Unexpected result transaction: pixel %02h last %b nr %b",
					got.pixel, got.last, got.not_ready));
			end else begin
				want = expected_pixels.pop_front();
				results_checked++;
				if (got.not_ready)
					not_ready_seen++;
				if (got.pixel !== want.pixel || got.last !== want.last ||
						got.not_ready !== want.not_ready)
					flag_error($sformatf(
						"Result mismatch: expected pixel %02h last %b nr %b, got %02h %b %b",
						want.pixel, want.last, want.not_ready,
						got.pixel, got.last, got.not_ready));
			end
		end
	end

	initial begin
		int phase, phase_base, wait_cycles;
		bit first_plane;
		orient_result_t none;

		none = '0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		error_count = 0;
		items_sent = 0;
		results_checked = 0;
		not_ready_seen = 0;
		planes_done = 0;
		modes_hit = '0;
		tx_idle_pct = 38;
		rx_idle_pct = 56;
		rx_hold_left = 0;
		fill_count = 0;
		col_pos = 0;
		row_pos = 0;
		plane_full = 1'b0;
		width_reg = DIM_W'(64);
		height_reg = DIM_W'(64);
		mode_reg = MODE_NONE;
		foreach (img_store[i])
			img_store[i] = '0;

		add_golden_row(CMD_READ, 8'h5A, 8'h00, 1'b0, 1'b1);
		add_cfg_row(REG_WIDTH, 7'd0);
		add_cfg_row(REG_HEIGHT, 7'd0);
		add_cfg_row(REG_SPARE, 7'h7F);
		add_item_row(CMD_WRITE, 8'hFF);
		add_item_row(CMD_WRITE, 8'h00);
		add_golden_row(CMD_READ, 8'h00, 8'hFF, 1'b1, 1'b0);
		add_golden_row(CMD_READ, 8'hFF, 8'h00, 1'b0, 1'b1);
		add_cfg_row(REG_WIDTH, 7'd3);
		add_cfg_row(REG_HEIGHT, 7'd2);
		add_cfg_row(REG_MODE, DIM_W'(MODE_ROT90));
		add_item_row(CMD_WRITE, 8'h01);
		add_item_row(CMD_WRITE, 8'h80);
		add_item_row(CMD_WRITE, 8'h7F);
		add_item_row(CMD_WRITE, 8'hFE);
		add_item_row(CMD_WRITE, 8'h55);
		add_item_row(CMD_WRITE, 8'hAA);
		add_item_row(CMD_READ, 8'h33);
		add_cfg_row(REG_WIDTH, 7'd1);
		add_cfg_row(REG_MODE, DIM_W'(MODE_MIRV));
		add_item_row(CMD_READ, 8'hCC);
		add_item_row(CMD_READ, 8'h0F);
		add_cfg_row(REG_WIDTH, 7'd4);
		add_cfg_row(REG_HEIGHT, 7'd4);
		add_cfg_row(REG_MODE, DIM_W'(MODE_ROT180));
		add_item_row(CMD_WRITE, 8'h11);
		add_item_row(CMD_WRITE, 8'h22);
		add_item_row(CMD_WRITE, 8'h44);
		add_item_row(CMD_WRITE, 8'h88);
		add_item_row(CMD_WRITE, 8'hF0);
		add_cfg_row(REG_WIDTH, 7'd2);
		add_cfg_row(REG_HEIGHT, 7'd2);
		add_item_row(CMD_WRITE, 8'h99);
		add_cfg_row(REG_MODE, DIM_W'(MODE_UNUSED));
		add_item_row(CMD_READ, 8'h00);
		add_item_row(CMD_READ, 8'h00);
		add_item_row(CMD_READ, 8'h00);
		add_item_row(CMD_READ, 8'h00);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				await_results();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				send_pixel_txn(directed_rows[i].cmd, directed_rows[i].pixel,
					directed_rows[i].typed, directed_rows[i].golden);
			end
		end

		for (phase = 0; phase < 3; phase++) begin
			await_results();
			tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 56 : 0;
			rx_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 38 : 0;
			phase_base = items_sent;
			first_plane = 1'b1;
			while (items_sent - phase_base < ITEMS_PER_PHASE) begin
				run_random_plane(phase == 2 && first_plane);
				first_plane = 1'b0;
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_cycles = 0;
		while (expected_pixels.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			$display("%0d expected results never arrived", expected_pixels.size());
			error_count += expected_pixels.size();
		end

		$display("Run covered %0d input transactions over %0d random planes, mode mask %b.",
			items_sent, planes_done, modes_hit);
		$display("Compared %0d result transactions, %0d of them not-ready responses.",
			results_checked, not_ready_seen);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
